// ===== sv/fsd_pkg.sv =====
// Shared types, constants and the quantizer function for the error-diffusion dither.
`timescale 1ns / 1ps
`default_nettype none
package fsd_pkg;

    // Width of one diffused error term, in sixteenths, signed
    localparam int ERR_W  = 13;
    // Width of one line-buffer word: three colour channels
    localparam int WORD_W = 3 * ERR_W;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic REG_QUANT_BITS  = 1'b1;

    localparam logic [11:0] IMAGE_WIDTH_RESET = 12'd640;
    localparam logic [3:0]  QUANT_BITS_RESET  = 4'd1;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // Item as classified by the front part
    typedef struct packed {
        pix_t pix;
        logic frame_start;
        logic last;
    } item_t;

    // Map a corrected channel value to its quantization level
    function automatic logic [7:0] quantize(input logic [7:0] v, input logic [3:0] bits);
        logic [3:0] b;
        logic [7:0] vm1;
        logic [7:0] mask;
        logic [8:0] top;
        begin
            b = bits;
            if (b == 4'd0)
            begin
                b = 4'd1;
            end
            if (b > 4'd8)
            begin
                b = 4'd8;
            end
            vm1  = v - 8'd1;
            mask = 8'hFF << (4'd8 - b);
            top  = 9'd256 - (9'd256 >> b);
            if (v == 8'd0)
            begin
                quantize = 8'd0;
            end
            else if ({1'b0, vm1} >= top)
            begin
                quantize = 8'd255;
            end
            else
            begin
                quantize = vm1 & mask;
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/fsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fsd_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [AW-1:0]            waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [AW-1:0]            raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/fsd_front.sv =====
// Front part: accepts pixels, tracks the column, classifies row ends and queues items.
`timescale 1ns / 1ps
`default_nettype none
module fsd_front #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire [31:0]             s_tdata,
    input  wire                    s_tuser,
    input  wire [11:0]             image_width,
    output logic                   q_valid,
    output fsd_pkg::item_t         q_item,
    output logic [CW-1:0]          q_col,
    input  wire                    q_pop
);
    localparam logic [13:0] MW14 = 14'(MAX_WIDTH);

    logic [CW-1:0]   col_reg, col_next;
    fsd_pkg::item_t  ent_item_reg [2];
    logic [CW-1:0]   ent_col_reg  [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    logic            push;
    logic [CW-1:0]   col;
    logic [13:0]     weff;
    logic            last;
    fsd_pkg::item_t  new_item;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        col  = s_tuser ? '0 : col_reg;
        weff = {2'b00, image_width};
        if (weff == 14'd0)
        begin
            weff = 14'd1;
        end
        if (weff > MW14)
        begin
            weff = MW14;
        end
        last = ((14'(col) + 14'd1) >= weff);
        new_item.pix         = s_tdata;
        new_item.frame_start = s_tuser;
        new_item.last        = last;
    end

    always_comb
    begin
        col_next    = col_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            col_next    = last ? '0 : col + CW'(1);
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            col_reg    <= col_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_item_reg[wr_ptr_reg] <= new_item;
            ent_col_reg[wr_ptr_reg]  <= col;
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = ent_item_reg[rd_ptr_reg];
    assign q_col   = ent_col_reg[rd_ptr_reg];
endmodule
`default_nettype wire

// ===== sv/fsd_back.sv =====
// Back part: line-buffer read, error correction, quantization, diffusion and output register.
`timescale 1ns / 1ps
`default_nettype none
module fsd_back #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    q_valid,
    input  wire fsd_pkg::item_t    q_item,
    input  wire [CW-1:0]           q_col,
    output logic                   q_pop,
    input  wire [3:0]              quant_bits,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [31:0]            m_tdata,
    output logic                   m_tlast
);
    localparam int BANKD = (MAX_WIDTH + 1) / 2;
    localparam int IW    = (BANKD > 1) ? $clog2(BANKD) : 1;
    localparam int EW    = fsd_pkg::ERR_W;
    localparam int WW    = fsd_pkg::WORD_W;

    function automatic logic [IW-1:0] cx_b_idx(input logic [CW-1:0] c);
        logic [CW:0] t;
        begin
            t = {1'b0, c};
            cx_b_idx = t[IW:1];
        end
    endfunction

    // read stage
    logic            b1_valid_reg, b1_valid_next;
    fsd_pkg::item_t  b1_item_reg;
    logic [CW-1:0]   b1_col_reg;
    // forwarding of the previous item's writes
    logic            fwda_valid_reg, fwdb_valid_reg;
    logic [CW-1:0]   fwda_addr_reg, fwdb_addr_reg;
    logic [WW-1:0]   fwda_data_reg, fwdb_data_reg;
    // diffusion state
    logic signed [EW-1:0] right_reg [3];
    logic signed [EW-1:0] bpart_reg [3];
    logic signed [EW-1:0] blpart_reg [3];
    logic [CW:0]     fill_reg, fill_next;
    // output register
    logic            out_valid_reg, out_valid_next;
    fsd_pkg::pix_t   out_pix_reg;
    logic            out_last_reg;

    logic            done;
    logic [WW-1:0]   even_rd, odd_rd, mem_word, mem_eff;
    logic            wa, wb;
    logic [CW-1:0]   addr_a;
    logic [WW-1:0]   data_a, data_b;
    logic            even_we, odd_we;
    logic [IW-1:0]   even_wi, odd_wi, rd_idx, idx_a, idx_b;
    logic [WW-1:0]   even_wd, odd_wd;
    logic [CW:0]     cx, ax;
    logic            fs;
    logic [7:0]      q_ch [3];
    logic signed [EW-1:0] d_ch [3];
    logic signed [EW-1:0] r_eff [3];
    logic signed [EW-1:0] b_eff [3];
    logic signed [EW-1:0] bl_eff [3];

    assign done           = b1_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop          = q_valid && (!b1_valid_reg || done);
    assign b1_valid_next  = q_pop ? 1'b1 : (done ? 1'b0 : b1_valid_reg);
    assign out_valid_next = done ? 1'b1 : ((out_valid_reg && m_tready) ? 1'b0 : out_valid_reg);

    assign cx     = {1'b0, q_col};
    assign rd_idx = cx[IW:1];

    fsd_ram #(.WIDTH(WW), .DEPTH(BANKD)) u_even (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_wi),
        .wdata (even_wd),
        .re    (q_pop),
        .raddr (rd_idx),
        .rdata (even_rd)
    );

    fsd_ram #(.WIDTH(WW), .DEPTH(BANKD)) u_odd (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_wi),
        .wdata (odd_wd),
        .re    (q_pop),
        .raddr (rd_idx),
        .rdata (odd_rd)
    );

    // Pick the newest copy of the entry at this column; zero at frame start or past the fill.
    always_comb
    begin
        fs       = b1_item_reg.frame_start;
        mem_word = b1_col_reg[0] ? odd_rd : even_rd;
        if (fs)
        begin
            mem_eff = '0;
        end
        else if (fwdb_valid_reg && fwdb_addr_reg == b1_col_reg)
        begin
            mem_eff = fwdb_data_reg;
        end
        else if (fwda_valid_reg && fwda_addr_reg == b1_col_reg)
        begin
            mem_eff = fwda_data_reg;
        end
        else if ({1'b0, b1_col_reg} < fill_reg)
        begin
            mem_eff = mem_word;
        end
        else
        begin
            mem_eff = '0;
        end
    end

    always_comb
    begin : ch_calc
        logic signed [EW-1:0] e;
        logic signed [EW:0]   es;
        logic signed [EW:0]   rs;
        logic signed [10:0]   v;
        logic [7:0]           vc;
        logic signed [9:0]    d9;
        for (int ch = 0; ch < 3; ch++)
        begin
            r_eff[ch]  = fs ? '0 : right_reg[ch];
            b_eff[ch]  = fs ? '0 : bpart_reg[ch];
            bl_eff[ch] = fs ? '0 : blpart_reg[ch];
            e  = r_eff[ch] + $signed(mem_eff[ch*EW +: EW]);
            es = {e[EW-1], e} + (EW+1)'(8);
            rs = es >>> 4;
            v  = $signed({3'b000, b1_item_reg.pix[ch*8 +: 8]}) + rs[10:0];
            if (v < 0)
            begin
                vc = 8'd0;
            end
            else if (v > 11'sd255)
            begin
                vc = 8'd255;
            end
            else
            begin
                vc = v[7:0];
            end
            q_ch[ch] = fsd_pkg::quantize(vc, quant_bits);
            d9       = $signed({2'b00, vc}) - $signed({2'b00, q_ch[ch]});
            d_ch[ch] = EW'(d9);
            data_a[ch*EW +: EW] = bl_eff[ch] + (d_ch[ch] <<< 1) + d_ch[ch];
            data_b[ch*EW +: EW] = b_eff[ch] + (d_ch[ch] <<< 2) + d_ch[ch];
        end
    end

    // Down-left write goes to column c-1, the row-end write to column c: opposite banks.
    always_comb
    begin
        wa     = done && (b1_col_reg != '0);
        wb     = done && b1_item_reg.last;
        addr_a = b1_col_reg - CW'(1);
        ax     = {1'b0, addr_a};
        idx_a  = ax[IW:1];
        idx_b  = cx_b_idx(b1_col_reg);
        even_we = (wa && !addr_a[0]) || (wb && !b1_col_reg[0]);
        odd_we  = (wa && addr_a[0]) || (wb && b1_col_reg[0]);
        if (wa && !addr_a[0])
        begin
            even_wi = idx_a;
            even_wd = data_a;
        end
        else
        begin
            even_wi = idx_b;
            even_wd = data_b;
        end
        if (wa && addr_a[0])
        begin
            odd_wi = idx_a;
            odd_wd = data_a;
        end
        else
        begin
            odd_wi = idx_b;
            odd_wd = data_b;
        end
        fill_next = fs ? '0 : fill_reg;
        if (wb && ({1'b0, b1_col_reg} + (CW+1)'(1)) > fill_next)
        begin
            fill_next = {1'b0, b1_col_reg} + (CW+1)'(1);
        end
        else if (wa && {1'b0, b1_col_reg} > fill_next)
        begin
            fill_next = {1'b0, b1_col_reg};
        end
        if (!done)
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwda_valid_reg <= 1'b0;
            fwdb_valid_reg <= 1'b0;
            fill_reg       <= '0;
            for (int ch = 0; ch < 3; ch++)
            begin
                right_reg[ch]  <= '0;
                bpart_reg[ch]  <= '0;
                blpart_reg[ch] <= '0;
            end
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            if (done)
            begin
                fwda_valid_reg <= wa;
                fwdb_valid_reg <= wb;
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (b1_item_reg.last)
                    begin
                        right_reg[ch]  <= '0;
                        bpart_reg[ch]  <= '0;
                        blpart_reg[ch] <= '0;
                    end
                    else
                    begin
                        blpart_reg[ch] <= data_b[ch*EW +: EW];
                        bpart_reg[ch]  <= d_ch[ch];
                        right_reg[ch]  <= (d_ch[ch] <<< 3) - d_ch[ch];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_item_reg <= q_item;
            b1_col_reg  <= q_col;
        end
        if (done)
        begin
            fwda_addr_reg     <= addr_a;
            fwda_data_reg     <= data_a;
            fwdb_addr_reg     <= b1_col_reg;
            fwdb_data_reg     <= data_b;
            out_pix_reg.red   <= q_ch[0];
            out_pix_reg.green <= q_ch[1];
            out_pix_reg.blue  <= q_ch[2];
            out_pix_reg.alpha <= b1_item_reg.pix.alpha;
            out_last_reg      <= b1_item_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;
endmodule
`default_nettype wire

// ===== sv/floyd_steinberg_dither.sv =====
// Top level of the Floyd-Steinberg error-diffusion dither with its register port.
`timescale 1ns / 1ps
`default_nettype none
// Dithers each colour channel of a raster-order RGBA stream to 2^quant_bits levels,
// diffusing 7/16 right, 3/16 down-left, 5/16 down and 1/16 down-right; alpha passes
// through. One item is taken per clock and one result leaves per clock when the
// downstream side keeps up; a result passes through the queue register, then the
// line-buffer read stage, then the output register before it is presented,
// the middle stage being set by the registered read of the line buffer. The line buffer
// is split into even and odd column banks so that the two writes of a row-end pixel
// land in one cycle. A fill count marks how much of the buffer belongs to the current
// frame, so frame start and reset take effect at once and need no clearing pass. Mark
// the first pixel of a frame with tuser; m_tlast flags the last pixel of each row.
module floyd_steinberg_dither #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire         clk,
    input  wire         rst_n,
    // pixel in
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,   // red_in, green_in, blue_in, alpha_in
    input  wire         s_tuser,   // frame_start
    // pixel out
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic        m_tlast,   // row_end
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [11:0]    image_width_reg;
    logic [3:0]     quant_bits_reg;
    logic           wr_en;

    logic           q_valid;
    logic           q_pop;
    fsd_pkg::item_t q_item;
    logic [CW-1:0]  q_col;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= fsd_pkg::IMAGE_WIDTH_RESET;
            quant_bits_reg  <= fsd_pkg::QUANT_BITS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                fsd_pkg::REG_IMAGE_WIDTH: image_width_reg <= pwdata[11:0];
                fsd_pkg::REG_QUANT_BITS:  quant_bits_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            fsd_pkg::REG_IMAGE_WIDTH: prdata = {20'd0, image_width_reg};
            fsd_pkg::REG_QUANT_BITS:  prdata = {28'd0, quant_bits_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Classify each item (column, row end) and hold it in a short queue.
    fsd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .image_width (image_width_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_col       (q_col),
        .q_pop       (q_pop)
    );

    // Read the line buffer, correct, quantize, diffuse and present the result.
    fsd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_col      (q_col),
        .q_pop      (q_pop),
        .quant_bits (quant_bits_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );
endmodule
`default_nettype wire

// ===== verif/floyd_steinberg_dither_tb.sv =====
// Self-checking testbench for the Floyd-Steinberg error-diffusion dither.
`timescale 1ns / 1ps
`default_nettype none
module floyd_steinberg_dither_tb;

    localparam int MAXW = 2048;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // red, green, blue, alpha
    logic        s_tuser;   // frame_start
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // red, green, blue, alpha
    logic        m_tlast;   // row_end
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    floyd_steinberg_dither #(.MAX_WIDTH(MAXW)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct {
        logic [31:0] pix;
        logic        row_end;
    } dithered_t;

    // Predictor state: registers, column and the diffused errors in sixteenths
    logic [11:0] cfg_width;
    logic [3:0]  cfg_bits;
    int          col;
    int          line_err [MAXW][3];
    int          err_right [3];
    int          err_below [3];
    int          err_below_left [3];

    dithered_t   dithered_q [$];
    int          mismatches;
    bit          rx_quiet;      // no receiver stalls in the last phase
    bit          tx_quiet;      // no sender gaps in the last phase
    int          hold_off;      // long receiver stall, in cycles

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int div_round16(input int e);
        int t;
        begin
            t = e + 8;
            if (t >= 0)
            begin
                return t / 16;
            end
            return -((-t + 15) / 16);
        end
    endfunction

    function automatic int level_of(input int v, input int bits);
        int margin;
        int idx;
        begin
            margin = 256 >> bits;
            if (v <= 0)
            begin
                return 0;
            end
            idx = (v - 1) / margin;
            if (idx >= (1 << bits) - 1)
            begin
                return 255;
            end
            return idx * margin;
        end
    endfunction

    task automatic clear_diffusion();
        begin
            for (int i = 0; i < MAXW; i++)
            begin
                line_err[i] = '{0, 0, 0};
            end
            err_right      = '{0, 0, 0};
            err_below      = '{0, 0, 0};
            err_below_left = '{0, 0, 0};
        end
    endtask

    // Work out the dithered pixel for one accepted item and queue it
    task automatic dither_pixel(input logic [31:0] pix, input logic fstart);
        int        w;
        int        b;
        int        c;
        bit        last;
        int        v;
        int        q;
        int        d;
        dithered_t r;
        begin
            w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : cfg_width);
            b = (cfg_bits == 0) ? 1 : ((cfg_bits > 8) ? 8 : cfg_bits);
            if (fstart)
            begin
                clear_diffusion();
                col = 0;
            end
            c    = (col >= MAXW) ? MAXW - 1 : col;
            last = (c >= w - 1);
            r.pix = pix;
            for (int ch = 0; ch < 3; ch++)
            begin
                v = pix[8*ch +: 8] + div_round16(err_right[ch] + line_err[c][ch]);
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                q = level_of(v, b);
                d = v - q;
                r.pix[8*ch +: 8] = q[7:0];
                if (c > 0)
                begin
                    line_err[c-1][ch] = err_below_left[ch] + 3 * d;
                end
                if (last)
                begin
                    line_err[c][ch]    = err_below[ch] + 5 * d;
                    err_right[ch]      = 0;
                    err_below[ch]      = 0;
                    err_below_left[ch] = 0;
                end
                else
                begin
                    err_below_left[ch] = err_below[ch] + 5 * d;
                    err_below[ch]      = d;
                    err_right[ch]      = 7 * d;
                end
            end
            r.row_end = last;
            col = last ? 0 : c + 1;
            dithered_q.push_back(r);
        end
    endtask

    // Register write: setup cycle then access cycle
    task automatic write_reg(input logic idx, input logic [31:0] val);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(negedge clk);
            penable <= 1'b1;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            if (idx == fsd_pkg::REG_IMAGE_WIDTH)
            begin
                cfg_width = val[11:0];
            end
            else
            begin
                cfg_bits = val[3:0];
            end
        end
    endtask

    // Offer one item, hold it until taken; random gap before it
    task automatic send_pixel(input logic [31:0] pix, input logic fstart);
        begin
            if (!tx_quiet && $urandom_range(0, 7) == 0)
            begin
                s_tvalid <= 1'b0;
                s_tuser  <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= pix;
            s_tuser  <= fstart;
            @(posedge clk);
            while (!s_tready)
            begin
                @(posedge clk);
            end
            dither_pixel(pix, fstart);
            @(negedge clk);
        end
    endtask

    // Drain: drop the offer, wait for every expected item, then some latency slack
    task automatic wait_drained();
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= 1'b0;
            while (dithered_q.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (8) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_pixel();
        return $urandom();
    endfunction

    // Directed: channel extremes, quant settings 0, 1, 2, 8 and 15, narrow and wide rows
    task automatic test_directed();
        begin
            write_reg(fsd_pkg::REG_IMAGE_WIDTH, 32'd4);
            write_reg(fsd_pkg::REG_QUANT_BITS, 32'd1);
            send_pixel(32'h0000_0000, 1'b1);
            send_pixel(32'hFFFF_FFFF, 1'b0);
            send_pixel(32'h8080_8080, 1'b0);
            send_pixel(32'h7F01_FE7F, 1'b0);
            send_pixel(32'h5500_FFAA, 1'b0);
            send_pixel(32'hAAFF_0055, 1'b0);
            send_pixel(32'h0180_8081, 1'b0);
            send_pixel(32'hFF7F_7F80, 1'b0);
            wait_drained();
            // Width 0 behaves as 1; bits 0 behaves as 1
            write_reg(fsd_pkg::REG_IMAGE_WIDTH, 32'd0);
            write_reg(fsd_pkg::REG_QUANT_BITS, 32'd0);
            send_pixel(32'h1234_7F80, 1'b1);
            send_pixel(32'h00FF_8180, 1'b0);
            wait_drained();
            // Bits above eight behave as eight; width at maximum
            write_reg(fsd_pkg::REG_QUANT_BITS, 32'd15);
            write_reg(fsd_pkg::REG_IMAGE_WIDTH, 32'd2048);
            send_pixel(32'hFFFE_0201, 1'b1);
            send_pixel(32'h00FF_0000, 1'b0);
            wait_drained();
            // Width beyond maximum saturates
            write_reg(fsd_pkg::REG_IMAGE_WIDTH, 32'd4095);
            write_reg(fsd_pkg::REG_QUANT_BITS, 32'd8);
            send_pixel(32'h0102_0304, 1'b1);
            wait_drained();
            // Shrink width mid-row: column already past the end
            write_reg(fsd_pkg::REG_IMAGE_WIDTH, 32'd1);
            write_reg(fsd_pkg::REG_QUANT_BITS, 32'd2);
            send_pixel(32'hC040_C040, 1'b0);
            send_pixel(32'h40C0_40C0, 1'b0);
            wait_drained();
        end
    endtask

    // Random frames under one setting, with the odd stray frame start
    task automatic run_frames(input int width, input int bits, input int count);
        int n;
        begin
            write_reg(fsd_pkg::REG_IMAGE_WIDTH, width);
            write_reg(fsd_pkg::REG_QUANT_BITS, bits);
            n = 0;
            while (n < count)
            begin
                send_pixel(rand_pixel(), (n == 0) || ($urandom_range(0, 150) == 0));
                n++;
            end
            wait_drained();
        end
    endtask

    task automatic test_random();
        begin
            run_frames(1, 1, 60);
            run_frames(2, 8, 80);
            run_frames(7, 3, 200);
            run_frames(16, 2, 250);
            run_frames(5, 5, 150);
            run_frames(2048, 4, 300);
            run_frames(33, 7, 250);
            run_frames(3, 6, 150);
        end
    endtask

    // Receiver stalls long enough for the block to fill and stall its input
    task automatic test_backpressure();
        begin
            write_reg(fsd_pkg::REG_IMAGE_WIDTH, 32'd9);
            write_reg(fsd_pkg::REG_QUANT_BITS, 32'd3);
            hold_off = 200;
            for (int i = 0; i < 120; i++)
            begin
                send_pixel(rand_pixel(), i == 0);
            end
            wait_drained();
        end
    endtask

    // Final phase without idling on either side
    task automatic test_full_rate();
        begin
            rx_quiet = 1'b1;
            tx_quiet = 1'b1;
            run_frames(12, 1, 300);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            else if (!rx_quiet && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        dithered_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (dithered_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: data=%h last=%b", m_tdata, m_tlast);
            end
            else
            begin
                e = dithered_q.pop_front();
                if (m_tdata !== e.pix || m_tlast !== e.row_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp data=%h last=%b, got data=%h last=%b",
                                 e.pix, e.row_end, m_tdata, m_tlast);
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
        hold_off = 0;
        cfg_width = fsd_pkg::IMAGE_WIDTH_RESET;
        cfg_bits = fsd_pkg::QUANT_BITS_RESET;
        col = 0;
        clear_diffusion();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_full_rate();
        if (mismatches == 0 && dithered_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/fsd_pkg.sv
sv/fsd_ram.sv
sv/fsd_front.sv
sv/fsd_back.sv
sv/floyd_steinberg_dither.sv
verif/floyd_steinberg_dither_tb.sv
